[hdl/irstf_pkg.sv]
package irstf_pkg;

	// request kinds carried on the input tuser
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// frame status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_ID     = 2'd1;
	localparam logic [1:0] ST_BAD_PACKET = 2'd2;
	localparam logic [1:0] ST_TIMEOUT    = 2'd3;

	// configuration register indexes
	localparam logic CFG_SENSOR_ADDRESS = 1'b0;
	localparam logic CFG_TIMEOUT_TICKS  = 1'b1;

	// frame layout
	localparam int unsigned FRAME_BYTES = 9;
	localparam logic [3:0] LAST_INDEX = 4'(FRAME_BYTES - 1);
	localparam logic [15:0] TICK_MAX = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// receiver state
	typedef struct packed {
		logic        armed;
		logic [3:0]  byte_index;
		logic [15:0] tick_count;
		logic [10:0] object_accum;
		logic [6:0]  ambient_accum;
		logic        range_error;
	} irstf_state_t;

	// one result transaction
	typedef struct packed {
		logic [1:0]  frame_status;
		logic        temp_ok;
		logic [10:0] object_temp;
		logic [6:0]  ambient_temp;
	} irstf_result_t;

endpackage

[hdl/ir_sensor_temp_frame_receiver.sv]
// channel  | signals                         | contents
// s_       | tvalid tready tdata tuser       | tdata rx_byte, tuser req_type
// m_       | tvalid tready tdata tuser       | tdata temp_ok/object/ambient, tuser status
// cfg_     | valid ready index data          | index 0 sensor_address, 1 timeout_ticks
//
// one transaction a cycle sustained while the output register is not held full;
// each item sits in the input register where the frame state is updated, and its
// result then lands in the output register, from which it is offered.
// reset clears the frame state, the stage valids and loads the register defaults.
// an item holds in the input register only while it has a result and the
// output register is full and not being taken.
module ir_sensor_temp_frame_receiver
	import irstf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] temp_ok, [11:1] object_temp, [18:12] ambient_temp, zero pad
	output logic [1:0]  m_tuser,   // [1:0] frame_status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [3:0]    sensor_address_q;
	logic [15:0]   timeout_ticks_q;
	logic          valid_s1;
	logic [1:0]    req_s1;
	logic [7:0]    byte_s1;
	irstf_state_t  state_q;
	irstf_state_t  state_nxt;
	logic          res_valid;
	irstf_result_t res;
	irstf_result_t res_s2;
	logic          valid_s2;
	logic          out_free;
	logic          advance_s1;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_address_q <= 4'd0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SENSOR_ADDRESS: sensor_address_q <= cfg_data[3:0];
				CFG_TIMEOUT_TICKS:  timeout_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame logic on the registered item
	irstf_core u_core (
		.cur            (state_q),
		.req_type       (req_s1),
		.rx_byte        (byte_s1),
		.sensor_address (sensor_address_q),
		.timeout_ticks  (timeout_ticks_q),
		.nxt            (state_nxt),
		.res_valid      (res_valid),
		.res            (res)
	);

	// handshake between the stages
	assign out_free = !valid_s2 || m_tready;
	assign advance_s1 = valid_s1 && (!res_valid || out_free);
	assign s_tready = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// frame state, updated as the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= advance_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser = res_s2.frame_status;
	assign m_tdata = {5'd0, res_s2.ambient_temp, res_s2.object_temp, res_s2.temp_ok};

endmodule

[hdl/irstf_core.sv]
module irstf_core
	import irstf_pkg::*;
(
	input  irstf_state_t  cur,
	input  logic [1:0]    req_type,
	input  logic [7:0]    rx_byte,
	input  logic [3:0]    sensor_address,
	input  logic [15:0]   timeout_ticks,
	output irstf_state_t  nxt,
	output logic          res_valid,
	output irstf_result_t res
);

	logic [3:0]   hi;
	logic [3:0]   lo;
	logic [15:0]  tick_inc;
	logic [1:0]   status;
	irstf_state_t upd;
	logic         good;

	assign hi = rx_byte[7:4];
	assign lo = rx_byte[3:0];
	assign tick_inc = (cur.tick_count != TICK_MAX) ? cur.tick_count + 16'd1 : cur.tick_count;

	// next state and result for one input transaction
	always_comb begin
		upd = cur;
		res_valid = 1'b0;
		status = ST_OK;
		unique case (req_type)
			REQ_START: begin
				upd = '0;
				upd.armed = 1'b1;
			end
			REQ_TICK: begin
				if (cur.armed) begin
					upd.tick_count = tick_inc;
					if (tick_inc >= timeout_ticks) begin
						res_valid = 1'b1;
						status = ST_TIMEOUT;
					end
				end
			end
			REQ_BYTE: begin
				if (cur.armed) begin
					if (cur.byte_index == 4'd0) begin
						if (rx_byte != {4'd0, sensor_address}) begin
							res_valid = 1'b1;
							status = ST_BAD_ID;
						end else begin
							upd.byte_index = cur.byte_index + 4'd1;
						end
					end else if (hi != cur.byte_index) begin
						res_valid = 1'b1;
						status = ST_BAD_PACKET;
					end else begin
						// gather nibbles and range checks by byte position
						case (cur.byte_index)
							4'd1: upd.object_accum = cur.object_accum | {7'd0, lo};
							4'd2: upd.object_accum = cur.object_accum | {3'd0, lo, 4'd0};
							4'd3: begin
								if (lo >= 4'd8) upd.range_error = 1'b1;
								else upd.object_accum = cur.object_accum | {lo[2:0], 8'd0};
							end
							4'd4: begin
								if (lo != 4'd0) upd.range_error = 1'b1;
							end
							4'd7: upd.ambient_accum = cur.ambient_accum | {3'd0, lo};
							4'd8: begin
								if (lo >= 4'd7) upd.range_error = 1'b1;
								else upd.ambient_accum = cur.ambient_accum | {lo[2:0], 4'd0};
							end
							default: ;
						endcase
						if (cur.byte_index >= LAST_INDEX) begin
							res_valid = 1'b1;
							status = ST_OK;
						end else begin
							upd.byte_index = cur.byte_index + 4'd1;
						end
					end
				end
			end
			default: ;
		endcase
		if (res_valid) upd.armed = 1'b0;
	end

	assign nxt = upd;

	// temp_ok and the temperature fields are zero unless the frame is ok and in range
	assign good = (status == ST_OK) && !upd.range_error;
	assign res.frame_status = status;
	assign res.temp_ok = good;
	assign res.object_temp = good ? upd.object_accum : 11'd0;
	assign res.ambient_temp = good ? upd.ambient_accum : 7'd0;

endmodule
